@@ hdl/iksd_pkg.sv @@
// Shared types and constants for the inline key XOR stream decoder.
`timescale 1ns / 1ps

package iksd_pkg;

  // Decoding modes
  typedef enum logic [1:0] {
    MODE_FIXED     = 2'd0,
    MODE_FIXED_NEG = 2'd1,
    MODE_INDEX     = 2'd2,
    MODE_ADD_FB    = 2'd3
  } mode_t;

  // Run status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_MODE  = 2'd0;
  localparam logic [1:0] CFG_IDX_KEY   = 2'd1;
  localparam logic [1:0] CFG_IDX_COUNT = 2'd2;

  // Smallest acceptable plaintext size in bytes
  localparam int unsigned MIN_BODY_BYTES = 32;

  // Configuration register file contents
  typedef struct packed {
    mode_t       coding_mode;
    logic [31:0] start_key;
    logic [7:0]  count_byte;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic [31:0] plain_word;
    logic [2:0]  valid_bytes;
    logic        last_result;
    logic [1:0]  run_status;
  } res_t;

endpackage

@@ hdl/iksd_cfg.sv @@
// Configuration register file: coding mode, start key and count byte.
`timescale 1ns / 1ps

module iksd_cfg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  output iksd_pkg::cfg_t  cfg
);
  import iksd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Always able to take a write; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_MODE:  cfg_nxt.coding_mode = mode_t'(cfg_data[1:0]);
        CFG_IDX_KEY:   cfg_nxt.start_key   = cfg_data;
        CFG_IDX_COUNT: cfg_nxt.count_byte  = cfg_data[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{coding_mode: MODE_FIXED, start_key: 32'd0, count_byte: 8'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/iksd_core.sv @@
// Input register, run state and combinational word decode.
`timescale 1ns / 1ps

module iksd_core #(
  parameter int unsigned BODY_LIMIT_BYTES = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  iksd_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [31:0]     in_body_word,
  input  logic            in_first_word,
  input  logic            in_end_of_data,
  input  logic            obuf_full,
  output logic            res_push,
  output iksd_pkg::res_t  res
);
  import iksd_pkg::*;

  // Byte counter holds up to the limit plus one partial word
  localparam int unsigned BW = $clog2(BODY_LIMIT_BYTES + 4);
  localparam logic [BW-1:0] LIMIT_B = BW'(BODY_LIMIT_BYTES);
  localparam logic [BW-1:0] MIN_B   = BW'(MIN_BODY_BYTES);

  // Input register
  logic        in_vld_r, in_vld_nxt;
  logic [31:0] word_r;
  logic        first_r;
  logic        eod_r;

  // Run state
  mode_t          mode_r, mode_nxt;
  logic [31:0]    key_r, key_nxt;
  logic [BW-1:0]  bd_r, bd_nxt;
  logic [BW-1:0]  total_r, total_nxt;
  logic           active_r, active_nxt;

  logic accept;
  logic go;

  // Start-of-run evaluation
  logic [7:0]  cnt8;
  logic [9:0]  tot10;
  logic        reject;

  // Per-word work
  logic [31:0]   pl;
  logic [BW-1:0] bd_add;
  logic [BW-1:0] rem;
  logic [2:0]    nbytes;
  logic [7:0]    idx8;

  assign in_stall = in_vld_r & obuf_full;
  assign accept   = in_valid & ~in_stall;
  assign go       = in_vld_r & ~obuf_full;

  // Input register
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (go) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r  <= in_body_word;
      first_r <= in_first_word;
      eod_r   <= in_end_of_data;
    end
  end

  // Count derived from config at run start
  always_comb begin
    cnt8   = (cfg.coding_mode == MODE_FIXED_NEG) ? 8'(-cfg.count_byte) : cfg.count_byte;
    tot10  = (cfg.coding_mode == MODE_INDEX) ? {2'b00, cnt8} : {cnt8, 2'b00};
    reject = (cnt8 == 8'd0) || (32'(tot10) < MIN_BODY_BYTES) ||
             (32'(tot10) > BODY_LIMIT_BYTES);
  end

  // Decode one word
  always_comb begin
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    bd_nxt     = bd_r;
    total_nxt  = total_r;
    active_nxt = active_r;
    res_push   = 1'b0;
    res        = '0;
    pl         = 32'd0;
    bd_add     = '0;
    rem        = '0;
    nbytes     = 3'd0;
    idx8       = 8'd0;

    if (go) begin
      // A start beat reloads the run from config
      if (first_r) begin
        mode_nxt   = cfg.coding_mode;
        key_nxt    = cfg.start_key;
        bd_nxt     = '0;
        total_nxt  = '0;
        active_nxt = 1'b1;
        if (cfg.coding_mode != MODE_ADD_FB) begin
          total_nxt = BW'(tot10);
          if (reject) begin
            active_nxt = 1'b0;
          end
        end
      end

      if (first_r && cfg.coding_mode != MODE_ADD_FB && reject) begin
        // Refused count: one empty closing beat
        res_push        = 1'b1;
        res.last_result = 1'b1;
        res.run_status  = ST_REJECT;
      end else if (active_nxt) begin
        res_push = 1'b1;
        if (mode_nxt == MODE_ADD_FB) begin
          // Additive feedback: key grows by each plaintext word
          pl              = word_r ^ key_nxt;
          bd_add          = bd_nxt + BW'(4);
          res.plain_word  = pl;
          res.valid_bytes = 3'd4;
          key_nxt         = key_nxt + pl;
          bd_nxt          = bd_add;
          if (pl == 32'd0 || eod_r || bd_add >= LIMIT_B) begin
            res.last_result = 1'b1;
            res.run_status  = (bd_add < MIN_B) ? ST_REJECT : ST_OK;
            active_nxt      = 1'b0;
          end
        end else begin
          // Counted modes
          rem    = (total_nxt > bd_nxt) ? (total_nxt - bd_nxt) : '0;
          nbytes = (rem > BW'(4)) ? 3'd4 : rem[2:0];
          if (mode_nxt == MODE_INDEX) begin
            for (int b = 0; b < 4; b++) begin
              idx8 = 8'(bd_nxt) + 8'(b + 1);
              if (3'(b) < nbytes) begin
                res.plain_word[8*b +: 8] = word_r[8*b +: 8] ^ idx8;
              end
            end
          end else begin
            res.plain_word = word_r ^ key_nxt;
          end
          res.valid_bytes = nbytes;
          bd_add          = bd_nxt + BW'(nbytes);
          bd_nxt          = bd_add;
          if (bd_add >= total_nxt) begin
            res.last_result = 1'b1;
            active_nxt      = 1'b0;
          end else if (eod_r) begin
            res.last_result = 1'b1;
            res.run_status  = ST_TRUNC;
            active_nxt      = 1'b0;
          end
        end
      end
    end
  end

  // Run state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_FIXED;
      key_r    <= 32'd0;
      bd_r     <= '0;
      total_r  <= '0;
      active_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      key_r    <= key_nxt;
      bd_r     <= bd_nxt;
      total_r  <= total_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

@@ hdl/iksd_obuf.sv @@
// Two-entry result buffer decoupling the decoder from the output stall.
`timescale 1ns / 1ps

module iksd_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  iksd_pkg::res_t  push_res,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output iksd_pkg::res_t  out_res
);
  import iksd_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  res_t       ent0_r, ent0_nxt;
  res_t       ent1_r, ent1_nxt;
  logic       pop;
  logic [1:0] wr_pos;

  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = ent0_r;
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid & ~out_stall;

  // Shift on pop, then write the new beat behind what remains
  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    if (pop) begin
      ent0_nxt = ent1_r;
    end
    wr_pos  = cnt_r - {1'b0, pop};
    cnt_nxt = wr_pos + {1'b0, push};
    if (push) begin
      if (wr_pos == 2'd0) begin
        ent0_nxt = push_res;
      end else begin
        ent1_nxt = push_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

endmodule

@@ hdl/inline_key_xor_stream_decoder.sv @@
// Top level of the inline key XOR stream decoder.
`timescale 1ns / 1ps

// Decodes a body given as little-endian 32-bit words, one beat per clock,
// with one result beat for each word of an active run (none for words seen
// while idle). A beat is captured in an input register, decoded
// combinationally (XOR, then for additive feedback the 32-bit key add that
// closes the key loop), and written into a two-entry result buffer that
// drives the out_ ports. Sustained rate is one word per cycle while
// out_stall stays low. in_stall rises only when the result buffer is full
// and a word is waiting in the input register. The configuration port is
// always ready; write it only while the block is idle. Mode, key and count
// are sampled when a first_word beat is decoded.
module inline_key_xor_stream_decoder #(
  parameter int unsigned BODY_LIMIT_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Encoded words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_body_word,
  input  logic        in_first_word,
  input  logic        in_end_of_data,
  // Decoded results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_plain_word,
  output logic [2:0]  out_valid_bytes,
  output logic        out_last_result,
  output logic [1:0]  out_run_status
);
  import iksd_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic res_push;
  logic obuf_full;

  iksd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  iksd_core #(
    .BODY_LIMIT_BYTES (BODY_LIMIT_BYTES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_body_word   (in_body_word),
    .in_first_word  (in_first_word),
    .in_end_of_data (in_end_of_data),
    .obuf_full      (obuf_full),
    .res_push       (res_push),
    .res            (res)
  );

  iksd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_res  (res),
    .full      (obuf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_plain_word  = out_res.plain_word;
  assign out_valid_bytes = out_res.valid_bytes;
  assign out_last_result = out_res.last_result;
  assign out_run_status  = out_res.run_status;

`ifndef SYNTH
  // Input stalls only when the result buffer has no room
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> obuf_full)
    else $error("in_stall without full result buffer");

  // The decoder never pushes into a full buffer
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !obuf_full)
    else $error("result pushed into full buffer");

  // A non-ok status only appears on the closing beat of a run
  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_run_status != ST_OK) |-> out_last_result)
    else $error("error status on non-final beat");

  // Never more than four meaningful bytes
  a_valid_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_bytes <= 3'd4))
    else $error("valid_bytes above four");
`endif

endmodule
